@@ hdl/permutation_order_crossover_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the permutation order crossover unit
// Clocked property checks on clk_i, with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef PERMUTATION_ORDER_CROSSOVER_UNIT_ASSERT_SVH
`define PERMUTATION_ORDER_CROSSOVER_UNIT_ASSERT_SVH

`ifndef SYNTH

`define POC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define POC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define POC_ASSERT(lbl, prop, msg)

`define POC_ASSERT_RST(lbl, prop, msg)

`endif

`endif

@@ hdl/poc_pkg.sv @@
// ----------------------------------------------------------------------------
// Order crossover package
// Field widths, slot limits and nibble helpers shared by the pipeline stages.
// ----------------------------------------------------------------------------
package poc_pkg;

  localparam int unsigned TaskW       = 4;
  localparam int unsigned TaskNum     = 1 << TaskW;
  localparam int unsigned FieldSlots  = 10;
  localparam int unsigned FieldW      = TaskW * FieldSlots;
  localparam int unsigned MaskW       = FieldSlots;
  localparam int unsigned MaxSlots    = 16;
  localparam int unsigned SlotsDefault = 10;

  function automatic logic [TaskW-1:0] field_nibble(logic [FieldW-1:0] v, int unsigned k);
    logic [FieldW-1:0] sh;
    logic [TaskW-1:0]  res;
    sh  = v >> (TaskW * k);
    res = '0;
    if (k < FieldSlots) begin
      res = sh[TaskW-1:0];
    end
    return res;
  endfunction

  function automatic logic mask_bit(logic [MaskW-1:0] m, int unsigned k);
    logic [MaskW-1:0] sh;
    logic             res;
    sh  = m >> k;
    res = 1'b0;
    if (k < MaskW) begin
      res = sh[0];
    end
    return res;
  endfunction

  function automatic int unsigned pack_slots(int unsigned n);
    return (n < FieldSlots) ? n : FieldSlots;
  endfunction

endpackage

@@ hdl/poc_decode.sv @@
// ----------------------------------------------------------------------------
// Decode stage
// Unpack donor and receiver slots, apply the take mask, mark tasks present.
// ----------------------------------------------------------------------------
module poc_decode #(
  parameter int unsigned SLOTS = poc_pkg::SlotsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [poc_pkg::FieldW-1:0]    donor_perm_i,
  input  logic [poc_pkg::FieldW-1:0]    receiver_perm_i,
  input  logic [poc_pkg::MaskW-1:0]     take_mask_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [poc_pkg::TaskW-1:0]     child_o [SLOTS],
  output logic [poc_pkg::TaskW-1:0]     recv_o [SLOTS],
  output logic [poc_pkg::TaskNum-1:0]   present_o
);

  logic                        valid_q;
  logic                        advance;
  logic [poc_pkg::TaskW-1:0]   child_d [SLOTS];
  logic [poc_pkg::TaskW-1:0]   child_q [SLOTS];
  logic [poc_pkg::TaskW-1:0]   recv_d [SLOTS];
  logic [poc_pkg::TaskW-1:0]   recv_q [SLOTS];
  logic [poc_pkg::TaskNum-1:0] present_d;
  logic [poc_pkg::TaskNum-1:0] present_q;

  assign advance = !valid_q || !stall_i;
  assign stall_o = !advance;

  always_comb begin
    present_d = '0;
    for (int unsigned k = 0; k < SLOTS; k++) begin
      child_d[k] = poc_pkg::mask_bit(take_mask_i, k) ?
                   poc_pkg::field_nibble(donor_perm_i, k) : '0;
      recv_d[k]  = poc_pkg::field_nibble(receiver_perm_i, k);
      present_d[child_d[k]] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      child_q   <= child_d;
      recv_q    <= recv_d;
      present_q <= present_d;
    end
  end

  assign valid_o   = valid_q;
  assign child_o   = child_q;
  assign recv_o    = recv_q;
  assign present_o = present_q;

endmodule

@@ hdl/poc_rank.sv @@
// ----------------------------------------------------------------------------
// Rank stage
// Flag fill candidates in the receiver and rank candidates and empty slots.
// ----------------------------------------------------------------------------
module poc_rank #(
  parameter int unsigned SLOTS = poc_pkg::SlotsDefault,
  parameter int unsigned RankW = $clog2(SLOTS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [poc_pkg::TaskW-1:0]     child_i [SLOTS],
  input  logic [poc_pkg::TaskW-1:0]     recv_i [SLOTS],
  input  logic [poc_pkg::TaskNum-1:0]   present_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [poc_pkg::TaskW-1:0]     child_o [SLOTS],
  output logic [poc_pkg::TaskW-1:0]     recv_o [SLOTS],
  output logic [SLOTS-1:0]              cand_o,
  output logic [SLOTS-1:0]              empty_o,
  output logic [RankW-1:0]              crank_o [SLOTS],
  output logic [RankW-1:0]              erank_o [SLOTS]
);

  logic                      valid_q;
  logic                      advance;
  logic [SLOTS-1:0]          dup;
  logic [SLOTS-1:0]          cand_d;
  logic [SLOTS-1:0]          cand_q;
  logic [SLOTS-1:0]          empty_d;
  logic [SLOTS-1:0]          empty_q;
  logic [SLOTS-1:0]          below;
  logic [RankW-1:0]          crank_d [SLOTS];
  logic [RankW-1:0]          crank_q [SLOTS];
  logic [RankW-1:0]          erank_d [SLOTS];
  logic [RankW-1:0]          erank_q [SLOTS];
  logic [poc_pkg::TaskW-1:0] child_q [SLOTS];
  logic [poc_pkg::TaskW-1:0] recv_q [SLOTS];

  assign advance = !valid_q || !stall_i;
  assign stall_o = !advance;

  always_comb begin
    for (int unsigned i = 0; i < SLOTS; i++) begin
      dup[i] = 1'b0;
      for (int unsigned j = 0; j < SLOTS; j++) begin
        if (j < i && recv_i[j] == recv_i[i]) begin
          dup[i] = 1'b1;
        end
      end
      cand_d[i]  = (recv_i[i] != '0) && !present_i[recv_i[i]] && !dup[i];
      empty_d[i] = (child_i[i] == '0);
    end
  end

  always_comb begin
    below = '0;
    for (int unsigned i = 0; i < SLOTS; i++) begin
      for (int unsigned j = 0; j < SLOTS; j++) begin
        below[j] = (j < i);
      end
      crank_d[i] = RankW'($countones(cand_d & below));
      erank_d[i] = RankW'($countones(empty_d & below));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      child_q <= child_i;
      recv_q  <= recv_i;
      cand_q  <= cand_d;
      empty_q <= empty_d;
      crank_q <= crank_d;
      erank_q <= erank_d;
    end
  end

  assign valid_o = valid_q;
  assign child_o = child_q;
  assign recv_o  = recv_q;
  assign cand_o  = cand_q;
  assign empty_o = empty_q;
  assign crank_o = crank_q;
  assign erank_o = erank_q;

endmodule

@@ hdl/poc_place.sv @@
// ----------------------------------------------------------------------------
// Place stage
// Fill each empty slot with the candidate of equal rank, pack and flag holes.
// ----------------------------------------------------------------------------
module poc_place #(
  parameter int unsigned SLOTS = poc_pkg::SlotsDefault,
  parameter int unsigned RankW = $clog2(SLOTS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [poc_pkg::TaskW-1:0]     child_i [SLOTS],
  input  logic [poc_pkg::TaskW-1:0]     recv_i [SLOTS],
  input  logic [SLOTS-1:0]              cand_i,
  input  logic [SLOTS-1:0]              empty_i,
  input  logic [RankW-1:0]              crank_i [SLOTS],
  input  logic [RankW-1:0]              erank_i [SLOTS],
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [poc_pkg::FieldW-1:0]    child_perm_o,
  output logic                          fill_error_o
);

  localparam int unsigned PackSlots = poc_pkg::pack_slots(SLOTS);

  logic                       valid_q;
  logic                       advance;
  logic [poc_pkg::TaskW-1:0]  fill [SLOTS];
  logic [poc_pkg::FieldW-1:0] child_perm_d;
  logic [poc_pkg::FieldW-1:0] child_perm_q;
  logic                       fill_error_d;
  logic                       fill_error_q;

  assign advance = !valid_q || !stall_i;
  assign stall_o = !advance;

  always_comb begin
    fill_error_d = 1'b0;
    for (int unsigned k = 0; k < SLOTS; k++) begin
      fill[k] = child_i[k];
      if (empty_i[k]) begin
        fill[k] = '0;
        for (int unsigned i = 0; i < SLOTS; i++) begin
          if (cand_i[i] && crank_i[i] == erank_i[k]) begin
            fill[k] = fill[k] | recv_i[i];
          end
        end
      end
      if (fill[k] == '0) begin
        fill_error_d = 1'b1;
      end
    end
  end

  always_comb begin
    child_perm_d = '0;
    for (int unsigned k = 0; k < PackSlots; k++) begin
      child_perm_d[poc_pkg::TaskW*k +: poc_pkg::TaskW] = fill[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      child_perm_q <= child_perm_d;
      fill_error_q <= fill_error_d;
    end
  end

  assign valid_o      = valid_q;
  assign child_perm_o = child_perm_q;
  assign fill_error_o = fill_error_q;

endmodule

@@ hdl/permutation_order_crossover_unit.sv @@
// ----------------------------------------------------------------------------
// Permutation order crossover unit
// Builds a child permutation from a masked donor and the receiver's order.
// ----------------------------------------------------------------------------
// One beat is taken every cycle while in_stall_o is low, and each beat
// passes through three register stages: decode (apply the take mask, mark tasks
// present), rank (flag receiver candidates, rank candidates and empty slots)
// and place (fill each empty slot with the candidate of matching rank). A
// stall on the output halts only the stages that hold data, so bubbles are
// squeezed out and in_stall_o rises only once all three stages are full.
// Slots that cannot be filled read 0 and raise fill_error_o.
module permutation_order_crossover_unit #(
  parameter int unsigned SLOTS = poc_pkg::SlotsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [poc_pkg::FieldW-1:0]  donor_perm_i,
  input  logic [poc_pkg::FieldW-1:0]  receiver_perm_i,
  input  logic [poc_pkg::MaskW-1:0]   take_mask_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [poc_pkg::FieldW-1:0]  child_perm_o,
  output logic                        fill_error_o
);

  `include "permutation_order_crossover_unit_assert.svh"

  localparam int unsigned RankW     = $clog2(SLOTS);
  localparam int unsigned PackSlots = poc_pkg::pack_slots(SLOTS);

  logic                        dec_valid;
  logic                        dec_stall;
  logic [poc_pkg::TaskW-1:0]   dec_child [SLOTS];
  logic [poc_pkg::TaskW-1:0]   dec_recv [SLOTS];
  logic [poc_pkg::TaskNum-1:0] dec_present;

  logic                        rnk_valid;
  logic                        rnk_stall;
  logic [poc_pkg::TaskW-1:0]   rnk_child [SLOTS];
  logic [poc_pkg::TaskW-1:0]   rnk_recv [SLOTS];
  logic [SLOTS-1:0]            rnk_cand;
  logic [SLOTS-1:0]            rnk_empty;
  logic [RankW-1:0]            rnk_crank [SLOTS];
  logic [RankW-1:0]            rnk_erank [SLOTS];

  logic                        out_hole;

  poc_decode #(
    .SLOTS (SLOTS)
  ) u_decode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (in_valid_i),
    .stall_o         (in_stall_o),
    .donor_perm_i    (donor_perm_i),
    .receiver_perm_i (receiver_perm_i),
    .take_mask_i     (take_mask_i),
    .valid_o         (dec_valid),
    .stall_i         (dec_stall),
    .child_o         (dec_child),
    .recv_o          (dec_recv),
    .present_o       (dec_present)
  );

  poc_rank #(
    .SLOTS (SLOTS),
    .RankW (RankW)
  ) u_rank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (dec_valid),
    .stall_o   (dec_stall),
    .child_i   (dec_child),
    .recv_i    (dec_recv),
    .present_i (dec_present),
    .valid_o   (rnk_valid),
    .stall_i   (rnk_stall),
    .child_o   (rnk_child),
    .recv_o    (rnk_recv),
    .cand_o    (rnk_cand),
    .empty_o   (rnk_empty),
    .crank_o   (rnk_crank),
    .erank_o   (rnk_erank)
  );

  poc_place #(
    .SLOTS (SLOTS),
    .RankW (RankW)
  ) u_place (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (rnk_valid),
    .stall_o      (rnk_stall),
    .child_i      (rnk_child),
    .recv_i       (rnk_recv),
    .cand_i       (rnk_cand),
    .empty_i      (rnk_empty),
    .crank_i      (rnk_crank),
    .erank_i      (rnk_erank),
    .valid_o      (out_valid_o),
    .stall_i      (out_stall_i),
    .child_perm_o (child_perm_o),
    .fill_error_o (fill_error_o)
  );

  always_comb begin
    out_hole = 1'b0;
    for (int unsigned k = 0; k < PackSlots; k++) begin
      if (child_perm_o[poc_pkg::TaskW*k +: poc_pkg::TaskW] == '0) begin
        out_hole = 1'b1;
      end
    end
  end

  `POC_ASSERT(a_no_hole_without_error, out_valid_o && !fill_error_o |-> !out_hole, "child slot empty without fill_error")
  `POC_ASSERT(a_stall_only_when_full, in_stall_o |-> dec_valid && rnk_valid && out_valid_o && out_stall_i, "input stalled with a bubble in the pipeline")
  `POC_ASSERT(a_accept_lands, in_valid_i && !in_stall_o |=> dec_valid, "accepted beat lost at decode stage")
  `POC_ASSERT_RST(a_reset_clears, !rst_ni |=> !out_valid_o, "output valid straight after reset")

endmodule

@@ tb/sv/permutation_order_crossover_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Order crossover unit testbench
// Drives donor, receiver and take-mask beats through the unit, predicts each
// child permutation and its fill flag in the bench, and compares every output
// beat in order. Covers directed corner cases, well-formed and broken
// permutations, random idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module permutation_order_crossover_unit_tb;

  import poc_pkg::*;

  localparam int unsigned Slots     = SlotsDefault;
  localparam int unsigned HoldLen   = 60;
  localparam int unsigned IdlePct   = 6;
  localparam int unsigned ShowLimit = 10;

  typedef struct packed {
    logic [FieldW-1:0] child;
    logic              err;
  } child_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              in_valid_i      = 1'b0;
  logic              in_stall_o;
  logic [FieldW-1:0] donor_perm_i    = '0;
  logic [FieldW-1:0] receiver_perm_i = '0;
  logic [MaskW-1:0]  take_mask_i     = '0;
  logic              out_valid_o;
  logic              out_stall_i     = 1'b0;
  logic [FieldW-1:0] child_perm_o;
  logic              fill_error_o;

  child_t      child_q[$];
  int unsigned mismatches = 0;
  logic        quiet      = 1'b0;
  int unsigned hold_reqs  = 0;
  int unsigned hold_seen  = 0;
  int unsigned hold_left  = 0;

  permutation_order_crossover_unit #(
    .SLOTS(Slots)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .donor_perm_i   (donor_perm_i),
    .receiver_perm_i(receiver_perm_i),
    .take_mask_i    (take_mask_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .child_perm_o   (child_perm_o),
    .fill_error_o   (fill_error_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic child_t crossover_child(logic [FieldW-1:0] donor,
                                             logic [FieldW-1:0] recv,
                                             logic [MaskW-1:0] mask);
    logic [TaskW-1:0] slot [Slots];
    logic [TaskW-1:0] cand;
    logic             seen;
    logic             placed;
    child_t           res;
    for (int k = 0; k < Slots; k++) begin
      slot[k] = mask[k] ? donor[TaskW*k +: TaskW] : '0;
    end
    for (int k = 0; k < Slots; k++) begin
      if (slot[k] == '0) begin
        placed = 1'b0;
        for (int i = 0; i < Slots; i++) begin
          if (!placed) begin
            cand = recv[TaskW*i +: TaskW];
            seen = 1'b0;
            for (int j = 0; j < Slots; j++) begin
              if (slot[j] == cand) seen = 1'b1;
            end
            if (!seen) begin
              slot[k] = cand;
              placed  = 1'b1;
            end
          end
        end
      end
    end
    res = '0;
    for (int k = 0; k < Slots; k++) begin
      if (slot[k] == '0) res.err = 1'b1;
      res.child[TaskW*k +: TaskW] = slot[k];
    end
    return res;
  endfunction

  task automatic send_beat(input logic [FieldW-1:0] donor,
                           input logic [FieldW-1:0] recv,
                           input logic [MaskW-1:0] mask);
    if (!quiet && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    donor_perm_i    <= donor;
    receiver_perm_i <= recv;
    take_mask_i     <= mask;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    child_q.insert(child_q.size(), crossover_child(donor, recv, mask));
  endtask

  task automatic shuffled_perm(output logic [FieldW-1:0] perm);
    int unsigned vals [Slots];
    int unsigned j;
    int unsigned tmp;
    for (int i = 0; i < Slots; i++) vals[i] = i + 1;
    for (int i = Slots - 1; i > 0; i--) begin
      j       = $urandom_range(i);
      tmp     = vals[i];
      vals[i] = vals[j];
      vals[j] = tmp;
    end
    perm = '0;
    for (int i = 0; i < Slots; i++) perm[TaskW*i +: TaskW] = TaskW'(vals[i]);
  endtask

  task automatic test_directed();
    send_beat(40'hA987654321, 40'h123456789A, 10'h000);
    send_beat(40'hA987654321, 40'h123456789A, 10'h3FF);
    send_beat(40'hA987654321, 40'h123456789A, 10'h155);
    send_beat(40'hA987654321, 40'h123456789A, 10'h2AA);
    send_beat(40'h0000000000, 40'hA987654321, 10'h3FF);
    send_beat(40'hA987654321, 40'h0000000000, 10'h00F);
    send_beat(40'h0000000000, 40'h0000000000, 10'h000);
    send_beat(40'hFFFFFFFFFF, 40'hFFFFFFFFFF, 10'h3FF);
    send_beat(40'hFFFFFFFFFF, 40'hA987654321, 10'h001);
    send_beat(40'hBCDEF54321, 40'hA987654321, 10'h3FF);
    send_beat(40'hA987654321, 40'hFEDCBA9876, 10'h0F0);
    send_beat(40'h1111111111, 40'hA987654321, 10'h3FF);
    send_beat(40'h1111111111, 40'hA987654321, 10'h003);
    send_beat(40'h0000000000, 40'h5555533333, 10'h000);
    send_beat(40'h7A0908070A, 40'h0A09080706, 10'h211);
    send_beat(40'hA987604321, 40'hA987654321, 10'h3FF);
    send_beat(40'h123456789A, 40'hA987654321, 10'h200);
    send_beat(40'hA987654321, 40'hA987654321, 10'h3FF);
    send_beat(40'h5A5A5A5A5A, 40'hA5A5A5A5A5, 10'h155);
    send_beat(40'h8000000000, 40'h0000000001, 10'h3FF);
  endtask

  task automatic test_quiet_stretch();
    logic [FieldW-1:0] donor;
    logic [FieldW-1:0] recv;
    quiet <= 1'b1;
    for (int n = 0; n < 200; n++) begin
      shuffled_perm(donor);
      shuffled_perm(recv);
      send_beat(donor, recv, MaskW'($urandom));
    end
    quiet <= 1'b0;
  endtask

  task automatic test_random_perms();
    logic [FieldW-1:0] donor;
    logic [FieldW-1:0] recv;
    logic [MaskW-1:0]  mask;
    for (int n = 0; n < 1000; n++) begin
      shuffled_perm(donor);
      shuffled_perm(recv);
      case ($urandom_range(7))
        0:       mask = '0;
        1:       mask = '1;
        2:       mask = MaskW'($urandom) & MaskW'($urandom);
        3:       mask = MaskW'($urandom) | MaskW'($urandom);
        default: mask = MaskW'($urandom);
      endcase
      send_beat(donor, recv, mask);
    end
  endtask

  task automatic test_broken_perms();
    logic [FieldW-1:0] donor;
    logic [FieldW-1:0] recv;
    logic [63:0]       raw;
    for (int n = 0; n < 250; n++) begin
      if ($urandom_range(2) == 0) begin
        raw   = {$urandom(), $urandom()};
        donor = raw[FieldW-1:0];
        raw   = {$urandom(), $urandom()};
        recv  = raw[FieldW-1:0];
      end else begin
        shuffled_perm(donor);
        shuffled_perm(recv);
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(1)) begin
            donor[TaskW*$urandom_range(Slots - 1) +: TaskW] = TaskW'($urandom);
          end else begin
            recv[TaskW*$urandom_range(Slots - 1) +: TaskW] = TaskW'($urandom);
          end
        end
      end
      send_beat(donor, recv, MaskW'($urandom));
    end
  endtask

  task automatic test_backpressure();
    logic [FieldW-1:0] donor;
    logic [FieldW-1:0] recv;
    for (int r = 0; r < 2; r++) begin
      hold_reqs <= hold_reqs + 1;
      for (int n = 0; n < 90; n++) begin
        shuffled_perm(donor);
        shuffled_perm(recv);
        send_beat(donor, recv, MaskW'($urandom));
      end
    end
  endtask

  // hold off the output for a long stretch on request, else stall at random unless quiet
  always @(posedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HoldLen;
    end
    if (hold_left != 0) begin
      hold_left   = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99) < IdlePct);
    end
  end

  always @(posedge clk_i) begin
    child_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (child_q.size() == 0) begin
        if (mismatches < ShowLimit) begin
          $display("unexpected beat: child %h err %b", child_perm_o, fill_error_o);
        end
        mismatches++;
      end else begin
        want = child_q.pop_front();
        if (child_perm_o !== want.child || fill_error_o !== want.err) begin
          if (mismatches < ShowLimit) begin
            $display("mismatch: child exp %h got %h, err exp %b got %b",
                     want.child, child_perm_o, want.err, fill_error_o);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_quiet_stretch();
    test_random_perms();
    test_broken_perms();
    test_backpressure();
    in_valid_i <= 1'b0;
    while (child_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && child_q.size() == 0) begin
      $display("permutation_order_crossover_unit verification clean");
    end else begin
      $display("permutation_order_crossover_unit verification failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("permutation_order_crossover_unit verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/poc_pkg.sv
hdl/poc_decode.sv
hdl/poc_rank.sv
hdl/poc_place.sv
hdl/permutation_order_crossover_unit.sv
tb/sv/permutation_order_crossover_unit_tb.sv
